@@ sv/rti_pkg.sv @@
`timescale 1ns / 1ps

package rti_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W = 10;
	localparam int NCH = 6;
	localparam logic [31:0] SIGN32 = 32'h8000_0000;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_EMPTY = 3'd0;
	localparam logic [2:0] ST_BEFORE = 3'd1;
	localparam logic [2:0] ST_AFTER = 3'd2;
	localparam logic [2:0] ST_SINGLE = 3'd3;
	localparam logic [2:0] ST_INTERP = 3'd4;
	localparam logic [2:0] ST_STORED = 3'd5;
	localparam logic [2:0] ST_FULL = 3'd6;
	localparam logic [2:0] ST_CLEARED = 3'd7;

	typedef enum logic [1:0] {
		K_APPEND,
		K_QUERY,
		K_CLEAR,
		K_FULL
	} cmd_kind_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_WRITE,
		B_RD_FIRST,
		B_CHK_FIRST,
		B_RD_LAST,
		B_CHK_LAST,
		B_SRCH_RD,
		B_SRCH_CHK,
		B_LO_RD,
		B_LO_CHK,
		B_HI_RD,
		B_HI_CHK,
		B_DIV,
		B_MUL,
		B_ACC,
		B_PT_RD,
		B_PT_CHK,
		B_EMIT
	} back_state_t;

endpackage

@@ sv/route_time_interpolator.sv @@
`timescale 1ns / 1ps

// Route time interpolator. A command (append point, query time, clear table) is
// taken at a rising edge where start is high and busy is low; opcode 3 is ignored and
// gives no result. Every other command gives exactly one result, shown for a single
// cycle while done is high; the receiver cannot stall it, so it must capture the
// result on that edge. Commands are classified and the point count and time ordering
// are settled in a front stage, then pass through a two-entry request queue to a back
// stage that owns the seven point memories (one write and one registered read port
// each). busy is high only while that queue is full. In the back stage, the binary
// search of a query spends a read state and a check state per memory read, the
// fraction comes from a one-bit-per-cycle divider, and one shared multiplier blends
// the six channels in turn. The memories need no clearing after reset.
module route_time_interpolator #(
	parameter int MAX_POINTS = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] stamp,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        harvest_mass,
	input  logic [31:0]        harvest_volume,
	input  logic [31:0]        hopper_mass,
	input  logic [31:0]        hopper_volume,
	output logic               done,
	output logic [2:0]         status,
	output logic [9:0]         ref_index,
	output logic signed [31:0] out_stamp,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [31:0]        out_harvest_mass,
	output logic [31:0]        out_harvest_volume,
	output logic [31:0]        out_hopper_mass,
	output logic [31:0]        out_hopper_volume
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int W = 2 + CW + 7 * rti_pkg::DATA_W;

	logic         q_full, q_empty, push, pop;
	logic [W-1:0] push_data, head;
	logic [191:0] out_data;
	logic [31:0]  ostamp;

	assign busy = q_full;

	// The front stage snapshots the point count into each request, so the back
	// stage sees the table exactly as it stood when the request was taken.
	rti_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy),
		.opcode(opcode), .stamp(stamp),
		.payload({pos_x, pos_y, harvest_mass, harvest_volume, hopper_mass, hopper_volume}),
		.push(push), .push_data(push_data)
	);

	rti_fifo #(.WIDTH(W)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	rti_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(q_empty), .cmd(head), .pop(pop),
		.done(done), .status(status), .ref_index(ref_index), .out_stamp(ostamp),
		.out_data(out_data)
	);

	assign out_stamp = ostamp;
	assign out_x = out_data[191:160];
	assign out_y = out_data[159:128];
	assign out_harvest_mass = out_data[127:96];
	assign out_harvest_volume = out_data[95:64];
	assign out_hopper_mass = out_data[63:32];
	assign out_hopper_volume = out_data[31:0];

endmodule

@@ sv/rti_ram.sv @@
`timescale 1ns / 1ps

module rti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/rti_fifo.sv @@
`timescale 1ns / 1ps

module rti_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full = (cnt_q == 2'd2);

endmodule

@@ sv/rti_front.sv @@
`timescale 1ns / 1ps

module rti_front #(
	parameter int MAX_POINTS = 1024,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int W = 2 + CW + 7 * rti_pkg::DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [1:0]   opcode,
	input  logic [31:0]  stamp,
	input  logic [191:0] payload,
	output logic         push,
	output logic [W-1:0] push_data
);

	logic [CW-1:0]       count_q;
	logic [31:0]         last_q;
	logic [31:0]         t_sat;
	rti_pkg::cmd_kind_t  kind;
	logic                is_full;

	// Stamps that run backward in time are held at the last stored stamp.
	always_comb begin
		t_sat = stamp;
		if (count_q != '0 && (stamp ^ rti_pkg::SIGN32) < (last_q ^ rti_pkg::SIGN32)) begin
			t_sat = last_q;
		end
	end

	assign is_full = (count_q == CW'(MAX_POINTS));

	always_comb begin
		case (opcode)
			rti_pkg::OP_APPEND: kind = is_full ? rti_pkg::K_FULL : rti_pkg::K_APPEND;
			rti_pkg::OP_QUERY: kind = rti_pkg::K_QUERY;
			rti_pkg::OP_CLEAR: kind = rti_pkg::K_CLEAR;
			default: kind = rti_pkg::K_CLEAR;
		endcase
	end

	assign push = accept && (opcode == rti_pkg::OP_APPEND || opcode == rti_pkg::OP_QUERY
		|| opcode == rti_pkg::OP_CLEAR);
	assign push_data = {kind, count_q, (kind == rti_pkg::K_APPEND) ? t_sat : stamp, payload};

	always_ff @(posedge clk) begin
		if (push && kind == rti_pkg::K_APPEND) begin
			last_q <= t_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (kind == rti_pkg::K_APPEND) begin
				count_q <= count_q + CW'(1);
			end else if (kind == rti_pkg::K_CLEAR) begin
				count_q <= '0;
			end
		end
	end

endmodule

@@ sv/rti_back.sv @@
`timescale 1ns / 1ps

module rti_back #(
	parameter int MAX_POINTS = 1024,
	parameter int FRAC_BITS = 16,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int AW = $clog2(MAX_POINTS),
	localparam int W = 2 + CW + 7 * rti_pkg::DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_empty,
	input  logic [W-1:0] cmd,
	output logic         pop,
	output logic         done,
	output logic [2:0]   status,
	output logic [9:0]   ref_index,
	output logic [31:0]  out_stamp,
	output logic [191:0] out_data
);

	localparam int MW = 33 + FRAC_BITS + 1;
	localparam int DCW = $clog2(FRAC_BITS + 1);

	rti_pkg::back_state_t state_q, state_d;

	rti_pkg::cmd_kind_t kind_q;
	logic [CW-1:0]        n_q, lo_q, hi_q, mid_q, mid, lo_n, hi_n;
	logic [31:0]          t_q, kt, key0, dt2_q, key1_q;
	logic [31:0]          din_q [rti_pkg::NCH];
	logic [31:0]          v1_q [rti_pkg::NCH];
	logic signed [32:0]   d_q [rti_pkg::NCH];
	logic [31:0]          res_q [rti_pkg::NCH];
	logic [AW-1:0]        pidx_q, raddr;
	logic [2:0]           st_q;
	logic [31:0]          rem_q;
	logic [32:0]          rem2;
	logic [FRAC_BITS-1:0] a_q;
	logic [DCW-1:0]       dcnt_q;
	logic [2:0]           ch_q;
	logic signed [MW-1:0] prod_q, rnd, shr;
	logic signed [32:0]   sum;
	logic                 we, srch_gt, done_q;
	logic [31:0]          wdata [7];
	logic [31:0]          rdata [7];
	logic [AW+rti_pkg::IDX_W-1:0] ref_wide;
	logic [9:0]           ref_q;

	function automatic logic [31:0] conv(input logic [31:0] v, input logic [2:0] ch);
		conv = (ch < 3'd2) ? (v ^ rti_pkg::SIGN32) : v;
	endfunction

	assign wdata[0] = t_q;
	for (genvar g = 0; g < 7; g++) begin : g_mem
		if (g > 0) begin : g_wd
			assign wdata[g] = din_q[g-1];
		end
		rti_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
			.clk(clk), .we(we), .waddr(n_q[AW-1:0]), .wdata(wdata[g]),
			.raddr(raddr), .rdata(rdata[g])
		);
	end

	assign kt = t_q ^ rti_pkg::SIGN32;
	assign key0 = rdata[0] ^ rti_pkg::SIGN32;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign srch_gt = key0 > kt;
	assign lo_n = srch_gt ? lo_q : mid_q + CW'(1);
	assign hi_n = srch_gt ? mid_q : hi_q;
	assign rem2 = {rem_q, 1'b0};
	assign rnd = prod_q + (MW'(1) <<< (FRAC_BITS - 1));
	assign shr = rnd >>> FRAC_BITS;
	assign sum = $signed({1'b0, v1_q[ch_q]}) + shr[32:0];

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		we = 1'b0;
		raddr = '0;
		case (state_q)
			rti_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					pop = 1'b1;
					case (rti_pkg::cmd_kind_t'(cmd[W-1 -: 2]))
						rti_pkg::K_APPEND: state_d = rti_pkg::B_WRITE;
						rti_pkg::K_QUERY: state_d = (cmd[W-3 -: CW] == '0) ? rti_pkg::B_EMIT
							: rti_pkg::B_RD_FIRST;
						default: state_d = rti_pkg::B_EMIT;
					endcase
				end
			end
			rti_pkg::B_WRITE: begin
				we = 1'b1;
				state_d = rti_pkg::B_EMIT;
			end
			rti_pkg::B_RD_FIRST: state_d = rti_pkg::B_CHK_FIRST;
			rti_pkg::B_CHK_FIRST: state_d = (kt < key0) ? rti_pkg::B_PT_RD : rti_pkg::B_RD_LAST;
			rti_pkg::B_RD_LAST: begin
				raddr = AW'(n_q - CW'(1));
				state_d = rti_pkg::B_CHK_LAST;
			end
			rti_pkg::B_CHK_LAST: begin
				if (kt > key0 || n_q == CW'(1)) begin
					state_d = rti_pkg::B_PT_RD;
				end else begin
					state_d = rti_pkg::B_SRCH_RD;
				end
			end
			rti_pkg::B_SRCH_RD: begin
				raddr = mid[AW-1:0];
				state_d = rti_pkg::B_SRCH_CHK;
			end
			rti_pkg::B_SRCH_CHK: begin
				if (lo_n < hi_n) begin
					state_d = rti_pkg::B_SRCH_RD;
				end else if (lo_n >= n_q || lo_n == '0) begin
					state_d = rti_pkg::B_PT_RD;
				end else begin
					state_d = rti_pkg::B_LO_RD;
				end
			end
			rti_pkg::B_LO_RD: begin
				raddr = AW'(lo_q - CW'(1));
				state_d = rti_pkg::B_LO_CHK;
			end
			rti_pkg::B_LO_CHK: state_d = rti_pkg::B_HI_RD;
			rti_pkg::B_HI_RD: begin
				raddr = lo_q[AW-1:0];
				state_d = rti_pkg::B_HI_CHK;
			end
			rti_pkg::B_HI_CHK: state_d = (key0 == key1_q) ? rti_pkg::B_PT_RD : rti_pkg::B_DIV;
			rti_pkg::B_DIV: begin
				if (dcnt_q == DCW'(FRAC_BITS - 1)) begin
					state_d = rti_pkg::B_MUL;
				end
			end
			rti_pkg::B_MUL: state_d = rti_pkg::B_ACC;
			rti_pkg::B_ACC: state_d = (ch_q == 3'(rti_pkg::NCH - 1)) ? rti_pkg::B_EMIT
				: rti_pkg::B_MUL;
			rti_pkg::B_PT_RD: begin
				raddr = pidx_q;
				state_d = rti_pkg::B_PT_CHK;
			end
			rti_pkg::B_PT_CHK: state_d = rti_pkg::B_EMIT;
			rti_pkg::B_EMIT: state_d = rti_pkg::B_IDLE;
			default: state_d = rti_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rti_pkg::B_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == rti_pkg::B_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rti_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					kind_q <= rti_pkg::cmd_kind_t'(cmd[W-1 -: 2]);
					n_q <= cmd[W-3 -: CW];
					t_q <= cmd[7*32-1 -: 32];
					for (int i = 0; i < rti_pkg::NCH; i++) begin
						din_q[i] <= cmd[(rti_pkg::NCH-1-i)*32 +: 32];
						res_q[i] <= '0;
					end
					ref_q <= '0;
					case (rti_pkg::cmd_kind_t'(cmd[W-1 -: 2]))
						rti_pkg::K_APPEND: st_q <= rti_pkg::ST_STORED;
						rti_pkg::K_FULL: st_q <= rti_pkg::ST_FULL;
						rti_pkg::K_CLEAR: st_q <= rti_pkg::ST_CLEARED;
						default: st_q <= rti_pkg::ST_EMPTY;
					endcase
				end
			end
			rti_pkg::B_CHK_FIRST: begin
				st_q <= rti_pkg::ST_BEFORE;
				pidx_q <= '0;
			end
			rti_pkg::B_CHK_LAST: begin
				if (kt > key0) begin
					st_q <= rti_pkg::ST_AFTER;
					pidx_q <= AW'(n_q - CW'(1));
				end else begin
					st_q <= rti_pkg::ST_SINGLE;
					pidx_q <= '0;
				end
				lo_q <= '0;
				hi_q <= n_q;
			end
			rti_pkg::B_SRCH_RD: mid_q <= mid;
			rti_pkg::B_SRCH_CHK: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				if (lo_n >= n_q) begin
					st_q <= rti_pkg::ST_AFTER;
					pidx_q <= AW'(n_q - CW'(1));
				end else begin
					st_q <= rti_pkg::ST_BEFORE;
					pidx_q <= '0;
				end
			end
			rti_pkg::B_LO_CHK: begin
				key1_q <= key0;
				for (int i = 0; i < rti_pkg::NCH; i++) begin
					v1_q[i] <= conv(rdata[i+1], 3'(i));
				end
			end
			rti_pkg::B_HI_CHK: begin
				st_q <= rti_pkg::ST_INTERP;
				pidx_q <= AW'(lo_q - CW'(1));
				dt2_q <= key0 - key1_q;
				rem_q <= kt - key1_q;
				dcnt_q <= '0;
				ch_q <= '0;
				for (int i = 0; i < rti_pkg::NCH; i++) begin
					d_q[i] <= $signed({1'b0, conv(rdata[i+1], 3'(i))}) - $signed({1'b0, v1_q[i]});
				end
			end
			rti_pkg::B_DIV: begin
				dcnt_q <= dcnt_q + DCW'(1);
				if (rem2 >= {1'b0, dt2_q}) begin
					rem_q <= 32'(rem2 - {1'b0, dt2_q});
					a_q <= {a_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem2[31:0];
					a_q <= {a_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			rti_pkg::B_MUL: prod_q <= d_q[ch_q] * $signed({1'b0, a_q});
			rti_pkg::B_ACC: begin
				res_q[ch_q] <= conv(sum[31:0], ch_q);
				ch_q <= ch_q + 3'd1;
				ref_q <= ref_wide[9:0];
			end
			rti_pkg::B_PT_CHK: begin
				for (int i = 0; i < rti_pkg::NCH; i++) begin
					res_q[i] <= rdata[i+1];
				end
				ref_q <= ref_wide[9:0];
			end
			default: begin
			end
		endcase
	end

	assign ref_wide = {{rti_pkg::IDX_W{1'b0}}, pidx_q};

	assign done = done_q;
	assign status = st_q;
	assign ref_index = ref_q;
	assign out_stamp = (kind_q == rti_pkg::K_QUERY) ? t_q : '0;
	always_comb begin
		for (int i = 0; i < rti_pkg::NCH; i++) begin
			out_data[(rti_pkg::NCH-1-i)*32 +: 32] = res_q[i];
		end
	end

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held for two cycles");
	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rti_pkg::B_SRCH_CHK |-> lo_q < hi_q) else $error("search range empty");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rti_pkg::B_DIV |-> rem_q < dt2_q) else $error("divider remainder too big");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == rti_pkg::B_IDLE && !cmd_empty) else $error("bad queue pop");

endmodule

@@ tb/route_time_interpolator_tb.sv @@
`timescale 1ns / 1ps

// Checks the route time interpolator against a predictor that keeps its own copy
// of the point table. Requests come from a queue that the initial block fills.
// The driver takes them from that queue, and the monitor compares every result
// with the oldest expectation.
module route_time_interpolator_tb;

	// Opcode 3 has no meaning, and the block drops it without a result.
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int TABLE_DEPTH = 1024;
	localparam int STALL_LIMIT = 4000;
	localparam longint unsigned KEY_MAX = 64'hFFFF_FFFF;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] stamp;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hmass;
		logic [31:0] hvol;
		logic [31:0] bmass;
		logic [31:0] bvol;
		bit          drain_first; // wait for every result before this request
	} route_req_t;

	typedef struct {
		logic [2:0]  status;
		logic [9:0]  index;
		logic [31:0] stamp;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hmass;
		logic [31:0] hvol;
		logic [31:0] bmass;
		logic [31:0] bvol;
	} route_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = rti_pkg::OP_QUERY;
	logic signed [31:0] stamp = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic [31:0]        harvest_mass = '0;
	logic [31:0]        harvest_volume = '0;
	logic [31:0]        hopper_mass = '0;
	logic [31:0]        hopper_volume = '0;
	logic               done;
	logic [2:0]         status;
	logic [9:0]         ref_index;
	logic signed [31:0] out_stamp;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic [31:0]        out_harvest_mass;
	logic [31:0]        out_harvest_volume;
	logic [31:0]        out_hopper_mass;
	logic [31:0]        out_hopper_volume;

	route_req_t    pending_reqs[$];
	route_result_t expected_results[$];
	int            error_count = 0;
	int            accepted_count = 0;
	int            stall_cycles = 0;

	// The predictor's own copy of the point table.
	logic [31:0] tbl_stamp[TABLE_DEPTH];
	logic [31:0] tbl_x[TABLE_DEPTH];
	logic [31:0] tbl_y[TABLE_DEPTH];
	logic [31:0] tbl_hmass[TABLE_DEPTH];
	logic [31:0] tbl_hvol[TABLE_DEPTH];
	logic [31:0] tbl_bmass[TABLE_DEPTH];
	logic [31:0] tbl_bvol[TABLE_DEPTH];
	int          tbl_count = 0;

	route_time_interpolator i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.opcode            (opcode),
		.stamp             (stamp),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.harvest_mass      (harvest_mass),
		.harvest_volume    (harvest_volume),
		.hopper_mass       (hopper_mass),
		.hopper_volume     (hopper_volume),
		.done              (done),
		.status            (status),
		.ref_index         (ref_index),
		.out_stamp         (out_stamp),
		.out_x             (out_x),
		.out_y             (out_y),
		.out_harvest_mass  (out_harvest_mass),
		.out_harvest_volume(out_harvest_volume),
		.out_hopper_mass   (out_hopper_mass),
		.out_hopper_volume (out_hopper_volume)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Signed times are ordered by their offset-binary form, so that a plain unsigned
	// compare gives the time order.
	function automatic logic [31:0] time_key(logic [31:0] v);
		return v ^ rti_pkg::SIGN32;
	endfunction

	// Linear blend with a Q0.16 fraction, rounded to nearest.
	function automatic logic [31:0] mix_channel(logic [31:0] v1, logic [31:0] v2,
			longint unsigned frac);
		longint unsigned one;
		longint unsigned sum;
		one = 64'd1 << 16;
		sum = (one - frac) * v1 + frac * v2 + (one >> 1);
		return sum[47:16];
	endfunction

	function automatic route_result_t end_point(logic [2:0] st, int idx, logic [31:0] t);
		route_result_t r;
		r.status = st;
		r.index = idx[9:0];
		r.stamp = t;
		r.x = tbl_x[idx];
		r.y = tbl_y[idx];
		r.hmass = tbl_hmass[idx];
		r.hvol = tbl_hvol[idx];
		r.bmass = tbl_bmass[idx];
		r.bvol = tbl_bvol[idx];
		return r;
	endfunction

	// Works out the result of one request and updates the table copy.
	function automatic route_result_t predict_route(route_req_t q);
		route_result_t   r;
		logic [31:0]     t;
		logic [31:0]     kt;
		int              lo;
		int              hi;
		int              mid;
		longint unsigned dt1;
		longint unsigned dt2;
		longint unsigned frac;
		r = '{default: '0};
		t = q.stamp;
		if (q.op == rti_pkg::OP_CLEAR) begin
			tbl_count = 0;
			r.status = rti_pkg::ST_CLEARED;
			return r;
		end
		if (q.op == rti_pkg::OP_APPEND) begin
			if (tbl_count >= TABLE_DEPTH) begin
				r.status = rti_pkg::ST_FULL;
				return r;
			end
			// An out-of-order stamp is raised to the last one so the table stays sorted.
			if (tbl_count > 0 && time_key(t) < time_key(tbl_stamp[tbl_count - 1]))
				t = tbl_stamp[tbl_count - 1];
			tbl_stamp[tbl_count] = t;
			tbl_x[tbl_count] = q.x;
			tbl_y[tbl_count] = q.y;
			tbl_hmass[tbl_count] = q.hmass;
			tbl_hvol[tbl_count] = q.hvol;
			tbl_bmass[tbl_count] = q.bmass;
			tbl_bvol[tbl_count] = q.bvol;
			tbl_count++;
			r.status = rti_pkg::ST_STORED;
			return r;
		end
		if (tbl_count == 0) begin
			r.status = rti_pkg::ST_EMPTY;
			r.stamp = t;
			return r;
		end
		kt = time_key(t);
		if (kt < time_key(tbl_stamp[0]))
			return end_point(rti_pkg::ST_BEFORE, 0, t);
		if (kt > time_key(tbl_stamp[tbl_count - 1]))
			return end_point(rti_pkg::ST_AFTER, tbl_count - 1, t);
		if (tbl_count == 1)
			return end_point(rti_pkg::ST_SINGLE, 0, t);
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (time_key(tbl_stamp[mid]) > kt)
				hi = mid;
			else
				lo = mid + 1;
		end
		if (lo >= tbl_count)
			return end_point(rti_pkg::ST_AFTER, tbl_count - 1, t);
		if (lo == 0)
			return end_point(rti_pkg::ST_BEFORE, 0, t);
		dt1 = longint'(kt) - longint'(time_key(tbl_stamp[lo - 1]));
		dt2 = longint'(time_key(tbl_stamp[lo])) - longint'(time_key(tbl_stamp[lo - 1]));
		if (dt2 == 0)
			return end_point(rti_pkg::ST_INTERP, lo - 1, t);
		frac = (dt1 << 16) / dt2;
		r.status = rti_pkg::ST_INTERP;
		r.index = 10'(lo - 1);
		r.stamp = t;
		// Positions are signed, so they are blended in offset binary.
		r.x = time_key(mix_channel(time_key(tbl_x[lo - 1]), time_key(tbl_x[lo]), frac));
		r.y = time_key(mix_channel(time_key(tbl_y[lo - 1]), time_key(tbl_y[lo]), frac));
		r.hmass = mix_channel(tbl_hmass[lo - 1], tbl_hmass[lo], frac);
		r.hvol = mix_channel(tbl_hvol[lo - 1], tbl_hvol[lo], frac);
		r.bmass = mix_channel(tbl_bmass[lo - 1], tbl_bmass[lo], frac);
		r.bvol = mix_channel(tbl_bvol[lo - 1], tbl_bvol[lo], frac);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		error_count++;
	endtask

	// Driver. A request leaves the queue only when the previous one has been taken
	// or start was low, so start never drops between back-to-back requests.
	always @(posedge clk or negedge arst_n) begin
		route_req_t nxt;
		bit         gap;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				accepted_count++;
				if (opcode != OP_NONE)
					expected_results.push_back(predict_route('{opcode, stamp, pos_x, pos_y,
						harvest_mass, harvest_volume, hopper_mass, hopper_volume, 1'b0}));
			end
			if (!start || !busy) begin
				// Requests 600 to 899 go out with no random gaps between them.
				gap = (accepted_count < 600 || accepted_count >= 900) &&
					$urandom_range(99) < 18;
				if (pending_reqs.size() > 0 && !gap &&
						(!pending_reqs[0].drain_first || expected_results.size() == 0)) begin
					nxt = pending_reqs.pop_front();
					start <= 1'b1;
					opcode <= nxt.op;
					stamp <= nxt.stamp;
					pos_x <= nxt.x;
					pos_y <= nxt.y;
					harvest_mass <= nxt.hmass;
					harvest_volume <= nxt.hvol;
					hopper_mass <= nxt.bmass;
					hopper_volume <= nxt.bvol;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. A result is valid for one cycle only, so it is taken on every done.
	always @(posedge clk) begin
		route_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d", $realtime, status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
				if (ref_index !== want.index) report_mismatch("ref_index", 32'(ref_index),
					32'(want.index));
				if (out_stamp !== want.stamp) report_mismatch("out_stamp", out_stamp, want.stamp);
				if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
				if (out_harvest_mass !== want.hmass)
					report_mismatch("out_harvest_mass", out_harvest_mass, want.hmass);
				if (out_harvest_volume !== want.hvol)
					report_mismatch("out_harvest_volume", out_harvest_volume, want.hvol);
				if (out_hopper_mass !== want.bmass)
					report_mismatch("out_hopper_mass", out_hopper_mass, want.bmass);
				if (out_hopper_volume !== want.bvol)
					report_mismatch("out_hopper_volume", out_hopper_volume, want.bvol);
			end
		end
	end

	// Watchdog. It counts cycles in which no request is taken.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_req(logic [1:0] op, logic [31:0] t, logic [31:0] x, logic [31:0] y,
			logic [31:0] hm, logic [31:0] hv, logic [31:0] bm, logic [31:0] bv,
			bit drain = 1'b0);
		pending_reqs.push_back('{op, t, x, y, hm, hv, bm, bv, drain});
	endtask

	task automatic add_query(logic [31:0] t);
		add_req(rti_pkg::OP_QUERY, t, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	task automatic add_append(logic [31:0] t);
		add_req(rti_pkg::OP_APPEND, t, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	// One episode of random traffic: clear, fill with points (mostly in time order),
	// then query times spread over and around the table.
	task automatic add_route(int points, int queries, int max_step);
		longint unsigned keys[$];
		longint unsigned k;
		longint unsigned lo_k;
		longint unsigned hi_k;
		int              pick;
		int              j;
		add_req(rti_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom_range(99) < 20);
		k = ($urandom_range(3) == 0) ? longint'($urandom) : longint'($urandom_range(2000))
			+ 64'h8000_0000 - 1000;
		for (int i = 0; i < points; i++) begin
			if ($urandom_range(99) < 3)
				add_req(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			if ($urandom_range(99) < 10 && keys.size() > 0) begin
				// Out of time order: the block raises it to the last stamp.
				add_append(32'(keys[$] - $urandom_range(5000)) ^ rti_pkg::SIGN32);
				keys.push_back(keys[$]);
			end else begin
				if ($urandom_range(99) < 5)
					k = k + $urandom;
				else
					k = k + $urandom_range(max_step);
				if (k > KEY_MAX)
					k = KEY_MAX;
				add_append(32'(k) ^ rti_pkg::SIGN32);
				keys.push_back(k);
			end
		end
		for (int i = 0; i < queries; i++) begin
			pick = $urandom_range(99);
			j = $urandom_range(keys.size() - 1);
			if (keys.size() == 0 || pick < 5) begin
				add_query($urandom);
			end else if (pick < 15) begin
				add_query(32'(keys[j]) ^ rti_pkg::SIGN32);
			end else if (pick < 25) begin
				add_query(32'(keys[0] - $urandom_range(keys[0] > 100 ? 100 : 0))
					^ rti_pkg::SIGN32);
			end else if (pick < 35) begin
				hi_k = keys[$] + $urandom_range(100);
				add_query(32'(hi_k > KEY_MAX ? KEY_MAX : hi_k) ^ rti_pkg::SIGN32);
			end else begin
				j = (j == keys.size() - 1 && j > 0) ? j - 1 : j;
				lo_k = keys[j];
				hi_k = (keys.size() > 1) ? keys[j + 1] : keys[j];
				k = lo_k + ((longint'($urandom) << 32 | $urandom) % (hi_k - lo_k + 1));
				add_query(32'(k) ^ rti_pkg::SIGN32);
			end
		end
	endtask

	initial begin
		// Directed part: empty table, single point, ends, raised stamps,
		// extreme values in every channel, and the widest possible time span.
		add_query(32'h1234_5678);
		add_append(32'd100);
		pending_reqs[$].x = 32'h8000_0000;
		pending_reqs[$].y = 32'h7FFF_FFFF;
		pending_reqs[$].hmass = 32'h0;
		pending_reqs[$].hvol = 32'hFFFF_FFFF;
		add_query(32'd100);
		add_query(32'd50);
		add_query(32'd200);
		add_append(32'd50);
		add_req(rti_pkg::OP_APPEND, 32'd1100, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0, 32'hFFFF_FFFF, 32'h0);
		add_query(32'd100);
		add_query(32'd600);
		add_query(32'd1099);
		add_query(32'd1100);
		add_req(OP_NONE, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1);
		add_req(rti_pkg::OP_CLEAR, '1, '1, '1, '1, '1, '1, '1);
		add_query(32'd100);
		add_req(rti_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			'0, '0, '0, '0);
		add_req(rti_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			'1, '1, '1, '1);
		add_query(32'h0);
		add_query(32'h8000_0000);
		add_query(32'h7FFF_FFFE);
		add_query(32'h7FFF_FFFF);

		// Random part. One episode fills the table past its end so that appends
		// are dropped as full; the rest are short routes.
		for (int ep = 0; pending_reqs.size() < 1550; ep++) begin
			if (ep == 6)
				add_route(TABLE_DEPTH + 4, 12, 50);
			else
				add_route($urandom_range(1, 24), $urandom_range(2, 14), 1000);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d results never arrived", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
